### rtl/vbr_pkg.sv
package vbr_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int LEN_W           = 11;
	localparam int MAX_BLOCK       = 1024;
	localparam int MAX_CHANNELS    = 2;
	localparam int CYCLE_W         = 13;
	localparam int CYCLE_MAX       = 4096;
	localparam int SINE_DEPTH_BITS = 8;
	localparam int SINE_DEPTH      = 1 << SINE_DEPTH_BITS;
	localparam int SINE_IDX_W      = SINE_DEPTH_BITS + 1;
	localparam int SINE_W          = 17;
	localparam int W_BITS          = 16;
	localparam int W_ONE           = 1 << W_BITS;
	localparam int DIV_N_W         = 11;
	localparam int DIV_STEP_W      = 5;
	localparam int CFG_DATA_W      = 13;

	localparam logic [10:0] BLOCK_FRAMES_RST  = 11'd256;
	localparam logic [1:0]  CHANNEL_COUNT_RST = 2'd2;
	localparam logic [9:0]  PEAK_FRAMES_RST   = 10'd0;
	localparam logic [12:0] CYCLE_BLOCKS_RST  = 13'd64;

	typedef enum logic [1:0] {
		CFG_BLOCK_FRAMES  = 2'd0,
		CFG_CHANNEL_COUNT = 2'd1,
		CFG_PEAK_FRAMES   = 2'd2,
		CFG_CYCLE_BLOCKS  = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_first;
		logic signed [SAMPLE_W-1:0] sample_second;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_first;
		logic signed [SAMPLE_W-1:0] out_second;
		logic                       run_last;
		logic                       block_done;
	} out_item_t;

	typedef struct packed {
		logic                  start;
		logic [DIV_N_W-1:0]    num;
		logic [DIV_N_W-1:0]    den;
		logic [DIV_STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [W_BITS-1:0] quo;
	} div_rsp_t;

	localparam int SINE_ROM_BITS = (SINE_DEPTH + 1) * SINE_W;

	// quarter-wave sine in Q16, degree-9 Taylor in Q30
	function automatic logic [SINE_ROM_BITS-1:0] build_sine_rom();
		logic [SINE_ROM_BITS-1:0] rom;
		longint unsigned t, x, x2, h, s, v;
		rom = '0;
		for (int r = 0; r <= SINE_DEPTH; r++) begin
			t  = (64'(r) << 30) / SINE_DEPTH;
			x  = (t * 64'd1686629713) >> 30;
			x2 = (x * x) >> 30;
			h  = 64'd1073741824 - x2 / 72;
			h  = 64'd1073741824 - ((x2 * h) >> 30) / 42;
			h  = 64'd1073741824 - ((x2 * h) >> 30) / 20;
			h  = 64'd1073741824 - ((x2 * h) >> 30) / 6;
			s  = (x * h) >> 30;
			v  = (s + 64'd8192) >> 14;
			if (v > 64'd65536) begin
				v = 64'd65536;
			end
			rom[r*SINE_W +: SINE_W] = v[SINE_W-1:0];
		end
		return rom;
	endfunction

	localparam logic [SINE_ROM_BITS-1:0] SINE_ROM = build_sine_rom();

endpackage

### rtl/vibrato_block_resampler_unit.sv
// Vibrato resampler: input frames are grouped into blocks of block_frames (L)
// frames, and each block is linearly resampled to M = L + delta frames, with
// delta following a quarter-wave sine ROM over cycle_blocks blocks (positive
// in the first half of the cycle, negative in the second). Results leave as
// soon as the input frames they need are in; each input item causes zero to
// four result items, the last one flagged run_last, and the final frame of a
// block (always input frame L-1) flagged block_done. The block takes one item
// at a time. Throughput is set by a single shared restoring divider (one
// quotient bit per cycle) and one shared multiplier: each interpolated output
// needs the Q0.16 weight division, 3 multiply/add steps per channel and
// position bookkeeping, and the first frame of a block adds the sine ROM index
// division and the new length M (no division is needed at the sine peak). A
// result waiting in the output register stalls the block only once the next
// result is ready.
module vibrato_block_resampler_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  src_valid,
	output logic                                  src_stall,
	input  vbr_pkg::in_item_t                     src_item,
	output logic                                  dst_valid,
	input  logic                                  dst_stall,
	output vbr_pkg::out_item_t                    dst_item,
	input  logic                                  cfg_we,
	input  logic [1:0]                            cfg_index,
	input  logic [vbr_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import vbr_pkg::*;

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_DELTA = 14'b00000000000010,
		ST_IDX   = 14'b00000000000100,
		ST_IDX_W = 14'b00000000001000,
		ST_ROM   = 14'b00000000010000,
		ST_LEN   = 14'b00000000100000,
		ST_RED   = 14'b00000001000000,
		ST_CHECK = 14'b00000010000000,
		ST_W_W   = 14'b00000100000000,
		ST_BA    = 14'b00001000000000,
		ST_BB    = 14'b00010000000000,
		ST_BC    = 14'b00100000000000,
		ST_ADV   = 14'b01000000000000,
		ST_LAST  = 14'b10000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [10:0] block_frames_q;
	logic [1:0]  channel_count_q;
	logic [9:0]  peak_frames_q;
	logic [12:0] cycle_blocks_q;

	// block state
	logic signed [SAMPLE_W-1:0] prior_q [2];
	logic signed [SAMPLE_W-1:0] carry_q [2];
	logic signed [SAMPLE_W-1:0] cur_q [2];
	logic signed [SAMPLE_W-1:0] prev_q [2];
	logic [9:0]        frame_pos_q;
	logic [11:0]       cycle_pos_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [LEN_W-1:0]  out_idx_q;
	logic [LEN_W-1:0]  qt_q;      // integer part of the next output position
	logic [LEN_W:0]    rem_q;     // fractional numerator of that position
	logic [1:0]        n_q;
	logic [LEN_W-1:0]  u_q;
	logic              neg_q;
	logic [9:0]        peak_q;
	logic [SINE_IDX_W-1:0] rom_idx_q;
	logic [9:0]        mag_q;
	logic [W_BITS-1:0] w_q;
	logic              ch_q;
	logic signed [33:0] acc_q;
	logic              pend_q;
	logic signed [SAMPLE_W-1:0] pend_first_q;
	logic signed [SAMPLE_W-1:0] pend_second_q;
	logic              dst_valid_q;
	out_item_t         dst_item_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	vbr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// effective settings
	logic [LEN_W-1:0] len;
	logic [9:0]       len_half;
	logic             two_ch;
	logic [12:0]      cb4;
	logic [12:0]      p;
	logic [11:0]      half;
	logic [10:0]      quarter;
	logic [11:0]      cp;
	logic [11:0]      qv;
	logic [11:0]      uv;
	logic [12:0]      cnext;
	logic             is_last;
	logic             cond;
	logic             slot_free;
	logic             can_go;
	logic [SINE_W-1:0] rom_val;
	logic [LEN_W-1:0] new_len;
	logic [16:0]      wc;
	logic signed [17:0] mul_x;
	logic signed [17:0] mul_y;
	logic signed [35:0] mul_p;
	logic signed [33:0] adj;
	logic signed [SAMPLE_W-1:0] blend_res;
	logic signed [SAMPLE_W-1:0] sel_a;
	logic signed [SAMPLE_W-1:0] sel_b;
	logic             accept;
	logic             load_pend;
	logic             load_last;

	always_comb begin
		if (block_frames_q < 11'd2) begin
			len = 11'd2;
		end else if (block_frames_q > 11'(MAX_BLOCK)) begin
			len = 11'(MAX_BLOCK);
		end else begin
			len = block_frames_q;
		end
		len_half = len[LEN_W-1:1];
		two_ch   = (MAX_CHANNELS > 1) && (channel_count_q > 2'd1);

		cb4 = {cycle_blocks_q[12:2], 2'b00};
		if (cb4 < 13'd4) begin
			p = 13'd4;
		end else if (cb4 > 13'(CYCLE_MAX)) begin
			p = 13'(CYCLE_MAX);
		end else begin
			p = cb4;
		end
		half    = p[12:1];
		quarter = p[12:2];
		cp      = ({1'b0, cycle_pos_q} >= p) ? 12'd0 : cycle_pos_q;
		qv      = (cp < half) ? cp : cp - half;
		uv      = (qv <= {1'b0, quarter}) ? qv : half - qv;
		cnext   = {1'b0, cycle_pos_q} + 13'd1;
	end

	assign is_last   = ({1'b0, frame_pos_q} + 11'd1) >= len;
	assign cond      = (n_q != 2'd3) && (out_len_q != '0)
		&& (({1'b0, out_idx_q} + 12'd1) < {1'b0, out_len_q})
		&& (qt_q == {1'b0, frame_pos_q});
	assign slot_free = !dst_valid_q || !dst_stall;
	assign can_go    = !pend_q || slot_free;
	assign accept    = (state_q == ST_IDLE) && src_valid;
	assign load_pend = (state_q == ST_CHECK) && pend_q && slot_free;
	assign load_last = (state_q == ST_LAST) && is_last && slot_free;

	assign rom_val  = SINE_ROM[rom_idx_q*SINE_W +: SINE_W];
	assign new_len  = neg_q ? len - {1'b0, mag_q} : len + {1'b0, mag_q};

	// one multiplier: sine magnitude, then the two blend terms per channel
	assign sel_a     = prev_q[ch_q];
	assign sel_b     = cur_q[ch_q];
	assign wc        = 17'(W_ONE) - {1'b0, w_q};

	always_comb begin
		unique case (state_q)
			ST_ROM: begin
				mul_x = {8'b0, peak_q};
				mul_y = {1'b0, rom_val};
			end
			ST_BB: begin
				mul_x = {{2{sel_b[SAMPLE_W-1]}}, sel_b};
				mul_y = {2'b00, w_q};
			end
			default: begin
				mul_x = {{2{sel_a[SAMPLE_W-1]}}, sel_a};
				mul_y = {1'b0, wc};
			end
		endcase
	end

	assign mul_p = mul_x * mul_y;

	// Q0.16 blend, truncated toward zero
	assign adj       = acc_q + (acc_q[33] ? 34'sd65535 : 34'sd0);
	assign blend_res = adj[31:16];

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = rem_q[DIV_N_W-1:0];
		div_req.den   = out_len_q;
		div_req.steps = DIV_STEP_W'(W_BITS);
		if (state_q == ST_IDX) begin
			div_req.start = (u_q != quarter);
			div_req.num   = u_q;
			div_req.den   = quarter;
			div_req.steps = DIV_STEP_W'(SINE_DEPTH_BITS);
		end else if (state_q == ST_CHECK) begin
			div_req.start = can_go && cond;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			block_frames_q  <= BLOCK_FRAMES_RST;
			channel_count_q <= CHANNEL_COUNT_RST;
			peak_frames_q   <= PEAK_FRAMES_RST;
			cycle_blocks_q  <= CYCLE_BLOCKS_RST;
			prior_q         <= '{default: '0};
			carry_q         <= '{default: '0};
			frame_pos_q     <= '0;
			cycle_pos_q     <= '0;
			out_len_q       <= '0;
			out_idx_q       <= '0;
			qt_q            <= '0;
			rem_q           <= '0;
			n_q             <= '0;
			pend_q          <= 1'b0;
			dst_valid_q     <= 1'b0;
		end else begin
			if (load_pend || load_last) begin
				dst_valid_q <= 1'b1;
			end else if (dst_valid_q && !dst_stall) begin
				dst_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q     <= '0;
						state_q <= (frame_pos_q == '0) ? ST_DELTA : ST_CHECK;
					end
				end
				ST_DELTA: begin
					cycle_pos_q <= cp;
					state_q     <= ST_IDX;
				end
				ST_IDX: begin
					state_q <= (u_q == quarter) ? ST_ROM : ST_IDX_W;
				end
				ST_IDX_W: begin
					if (div_rsp.done) begin
						state_q <= ST_ROM;
					end
				end
				ST_ROM: begin
					state_q <= ST_LEN;
				end
				ST_LEN: begin
					out_len_q <= new_len;
					out_idx_q <= '0;
					qt_q      <= '0;
					rem_q     <= {1'b0, len};
					state_q   <= ST_RED;
				end
				ST_RED: begin
					if (rem_q >= {1'b0, out_len_q}) begin
						rem_q <= rem_q - {1'b0, out_len_q};
						qt_q  <= qt_q + 1'b1;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (can_go) begin
						pend_q  <= 1'b0;
						state_q <= cond ? ST_W_W : ST_LAST;
					end
				end
				ST_W_W: begin
					if (div_rsp.done) begin
						state_q <= ST_BA;
					end
				end
				ST_BA: begin
					state_q <= ST_BB;
				end
				ST_BB: begin
					state_q <= ST_BC;
				end
				ST_BC: begin
					state_q <= (!ch_q && two_ch) ? ST_BA : ST_ADV;
				end
				ST_ADV: begin
					out_idx_q <= out_idx_q + 1'b1;
					n_q       <= n_q + 1'b1;
					rem_q     <= rem_q + {1'b0, len};
					pend_q    <= 1'b1;
					state_q   <= ST_RED;
				end
				ST_LAST: begin
					if (!is_last) begin
						frame_pos_q <= frame_pos_q + 1'b1;
						prior_q     <= cur_q;
						state_q     <= ST_IDLE;
					end else if (slot_free) begin
						carry_q     <= cur_q;
						prior_q     <= cur_q;
						frame_pos_q <= '0;
						out_idx_q   <= '0;
						cycle_pos_q <= (cnext >= p) ? 12'd0 : cnext[11:0];
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// the user must write these only while idle; the block does not enforce it
			if (cfg_we) begin
				unique case (cfg_index_t'(cfg_index))
					CFG_BLOCK_FRAMES: begin
						block_frames_q <= cfg_data[10:0];
						frame_pos_q    <= '0;
						out_idx_q      <= '0;
					end
					CFG_CHANNEL_COUNT: channel_count_q <= cfg_data[1:0];
					CFG_PEAK_FRAMES:   peak_frames_q   <= cfg_data[9:0];
					CFG_CYCLE_BLOCKS:  cycle_blocks_q  <= cfg_data[12:0];
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q[0] <= src_item.sample_first;
			cur_q[1] <= two_ch ? src_item.sample_second : '0;
			prev_q   <= (frame_pos_q == '0) ? carry_q : prior_q;
		end
		if (state_q == ST_DELTA) begin
			u_q    <= uv[LEN_W-1:0];
			neg_q  <= cp >= half;
			peak_q <= (peak_frames_q > len_half) ? len_half : peak_frames_q;
		end
		if (state_q == ST_IDX && u_q == quarter) begin
			rom_idx_q <= SINE_IDX_W'(SINE_DEPTH);
		end
		if (state_q == ST_IDX_W && div_rsp.done) begin
			rom_idx_q <= div_rsp.quo[SINE_IDX_W-1:0];
		end
		if (state_q == ST_ROM) begin
			mag_q <= mul_p[25:16];
		end
		if (state_q == ST_W_W && div_rsp.done) begin
			w_q  <= div_rsp.quo;
			ch_q <= 1'b0;
		end
		if (state_q == ST_BA) begin
			acc_q <= $signed(mul_p[33:0]);
		end
		if (state_q == ST_BB) begin
			acc_q <= acc_q + $signed(mul_p[33:0]);
		end
		if (state_q == ST_BC) begin
			if (!ch_q) begin
				pend_first_q  <= blend_res;
				pend_second_q <= '0;
				ch_q          <= 1'b1;
			end else begin
				pend_second_q <= blend_res;
			end
		end
		if (load_pend) begin
			dst_item_q.out_first  <= pend_first_q;
			dst_item_q.out_second <= pend_second_q;
			dst_item_q.run_last   <= !cond && !is_last;
			dst_item_q.block_done <= 1'b0;
		end else if (load_last) begin
			dst_item_q.out_first  <= cur_q[0];
			dst_item_q.out_second <= cur_q[1];
			dst_item_q.run_last   <= 1'b1;
			dst_item_q.block_done <= 1'b1;
		end
	end

	assign src_stall = (state_q != ST_IDLE);
	assign dst_valid = dst_valid_q;
	assign dst_item  = dst_item_q;

`ifndef SYNTH
	a_len_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (out_len_q != '0))
		else $error("block length zero while checking outputs");
	a_rem_lt_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (rem_q < {1'b0, out_len_q}))
		else $error("position remainder not reduced");
	a_no_pend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LAST) |-> !pend_q)
		else $error("interpolated item left behind at frame end");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && dst_item.block_done) |-> dst_item.run_last)
		else $error("block end item not flagged last");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> !div_rsp.done)
		else $error("divider restarted with result pending");
`endif

endmodule

### rtl/vbr_div.sv
module vbr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  vbr_pkg::div_req_t req,
	output vbr_pkg::div_rsp_t rsp
);
	import vbr_pkg::*;

	// restoring divider, one quotient bit per cycle; num < den on entry
	logic                  busy_q;
	logic                  done_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic [DIV_N_W-1:0]    r_q;
	logic [DIV_N_W-1:0]    d_q;
	logic [W_BITS-1:0]     quo_q;
	logic [DIV_N_W:0]      trial;
	logic                  fits;

	assign trial = {r_q, 1'b0};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q   <= req.num;
			d_q   <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				r_q <= DIV_N_W'(trial - {1'b0, d_q});
			end else begin
				r_q <= trial[DIV_N_W-1:0];
			end
			quo_q <= {quo_q[W_BITS-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

### test/vibrato_block_resampler_unit_tb.sv
module vibrato_block_resampler_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vbr_pkg::*;

	// Quiet cycles let after the last result before a register write or the end.
	localparam int SETTLE = 200;
	// Cycles with no handshake at all before giving up. This covers the long
	// receiver hold-off plus the slowest item.
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;

	logic       clk;
	logic       arst_n;
	logic       src_valid;
	logic       src_stall;
	in_item_t   src_item;
	logic       dst_valid;
	logic       dst_stall;
	out_item_t  dst_item;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	vibrato_block_resampler_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall), .src_item(src_item),
		.dst_valid(dst_valid), .dst_stall(dst_stall), .dst_item(dst_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// frames waiting to be offered, and resampled frames still owed by the block
	in_item_t  frame_q[$];
	out_item_t owed_q[$];

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_go;
	bit hold_done;
	int hold_left;
	bit src_took;
	int quiet_cycles;
	int errors;
	int frames_in;
	int frames_out;
	int blocks_done;

	// predictor copy of the registers and of the resampler state
	logic [10:0] m_len;
	logic [1:0]  m_chans;
	logic [9:0]  m_peak;
	logic [12:0] m_cycle;
	int          m_prior[2];
	int          m_carry[2];
	int unsigned m_fpos;
	int unsigned m_cpos;
	int unsigned m_olen;
	int unsigned m_oidx;
	int unsigned m_acc;
	int unsigned sine_q16[0:SINE_DEPTH];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Quarter-wave sine table, Q16, from a truncating Q30 Taylor series.
	function automatic void fill_sine();
		longint unsigned one, t, x, x2, h, v;
		one = 64'd1 << 30;
		for (int r = 0; r <= SINE_DEPTH; r++) begin
			t  = (64'(r) << 30) / SINE_DEPTH;
			x  = (t * 64'd1686629713) >> 30;
			x2 = (x * x) >> 30;
			h  = one - x2 / 72;
			h  = one - ((x2 * h) >> 30) / 42;
			h  = one - ((x2 * h) >> 30) / 20;
			h  = one - ((x2 * h) >> 30) / 6;
			v  = (((x * h) >> 30) + 64'd8192) >> 14;
			sine_q16[r] = (v > 64'd65536) ? 65536 : int'(v);
		end
	endfunction

	function automatic int unsigned frames_per_block();
		int unsigned l;
		l = m_len;
		if (l < 2) l = 2;
		if (l > MAX_BLOCK) l = MAX_BLOCK;
		return l;
	endfunction

	function automatic int unsigned live_chans();
		if (m_chans == 0) return 1;
		if (m_chans > MAX_CHANNELS) return MAX_CHANNELS;
		return m_chans;
	endfunction

	function automatic int unsigned blocks_per_cycle();
		int unsigned p;
		p = m_cycle & 13'h1ffc;
		if (p < 4) p = 4;
		if (p > CYCLE_MAX) p = CYCLE_MAX;
		return p;
	endfunction

	// length change for the block that starts now; wraps the cycle position
	function automatic int block_stretch(int unsigned len);
		int unsigned p, half, quarter, q, u, pk;
		longint unsigned mag;
		p = blocks_per_cycle();
		if (m_cpos >= p) m_cpos = 0;
		half    = p / 2;
		quarter = p / 4;
		q  = (m_cpos < half) ? m_cpos : m_cpos - half;
		u  = (q <= quarter) ? q : half - q;
		pk = (m_peak > len / 2) ? len / 2 : m_peak;
		mag = (64'(pk) * sine_q16[(u * SINE_DEPTH) / quarter]) >> 16;
		return (m_cpos < half) ? int'(mag) : -int'(mag);
	endfunction

	function automatic logic [15:0] mix(int a, int b, int unsigned w);
		longint sum;
		sum = longint'(a) * (W_ONE - w) + longint'(b) * w;
		return 16'(sum / W_ONE);
	endfunction

	function automatic void apply_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_BLOCK_FRAMES: begin
				m_len  = val[10:0];
				m_fpos = 0;
				m_oidx = 0;
			end
			CFG_CHANNEL_COUNT: m_chans = val[1:0];
			CFG_PEAK_FRAMES:   m_peak  = val[9:0];
			CFG_CYCLE_BLOCKS:  m_cycle = val[12:0];
		endcase
	endfunction

	// Resample step for one accepted input frame: queues the frames it owes.
	function automatic void resample_frame(in_item_t it);
		int unsigned len, w;
		int          cur[2], prev[2];
		out_item_t   made[$];
		out_item_t   o;
		bit          two;
		len = frames_per_block();
		two = live_chans() > 1;
		cur[0] = int'(it.sample_first);
		cur[1] = two ? int'(it.sample_second) : 0;
		if (m_fpos == 0) begin
			m_olen = int'(len) + block_stretch(len);
			m_oidx = 0;
			m_acc  = len;
			prev   = m_carry;
		end else begin
			prev = m_prior;
		end
		while (made.size() < 3 && m_olen > 0 && m_oidx + 1 < m_olen
		       && m_acc / m_olen == m_fpos) begin
			w = int'(((64'(m_acc % m_olen)) << 16) / m_olen);
			o.out_first  = mix(prev[0], cur[0], w);
			o.out_second = two ? mix(prev[1], cur[1], w) : '0;
			o.run_last   = 1'b0;
			o.block_done = 1'b0;
			made.push_back(o);
			m_oidx++;
			m_acc += len;
		end
		if (m_fpos + 1 >= len) begin
			// last input frame of the block passes through unchanged
			o.out_first  = 16'(cur[0]);
			o.out_second = 16'(cur[1]);
			o.run_last   = 1'b0;
			o.block_done = 1'b1;
			made.push_back(o);
			m_carry = cur;
			m_fpos  = 0;
			m_oidx  = 0;
			m_cpos++;
			if (m_cpos >= blocks_per_cycle()) m_cpos = 0;
		end else begin
			m_fpos++;
		end
		m_prior = cur;
		if (made.size() > 0) made[made.size()-1].run_last = 1'b1;
		foreach (made[i]) owed_q.push_back(made[i]);
	endfunction

	// Input handshake, output checks and the watchdog, all at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			src_took <= src_valid && !src_stall;
			if (src_valid && !src_stall) begin
				resample_frame(src_item);
				frames_in++;
			end
			if (dst_valid && !dst_stall) begin
				frames_out++;
				if (owed_q.size() == 0) begin
					$display("%0t: unexpected output %p", $realtime, dst_item);
					errors++;
				end else begin
					out_item_t e;
					e = owed_q.pop_front();
					if (e.block_done) blocks_done++;
					if (e.out_first !== dst_item.out_first) begin
						$display("%0t: out_first expected %0d got %0d",
						         $realtime, e.out_first, dst_item.out_first);
						errors++;
					end
					if (e.out_second !== dst_item.out_second) begin
						$display("%0t: out_second expected %0d got %0d",
						         $realtime, e.out_second, dst_item.out_second);
						errors++;
					end
					if (e.run_last !== dst_item.run_last) begin
						$display("%0t: run_last expected %0b got %0b",
						         $realtime, e.run_last, dst_item.run_last);
						errors++;
					end
					if (e.block_done !== dst_item.block_done) begin
						$display("%0t: block_done expected %0b got %0b",
						         $realtime, e.block_done, dst_item.block_done);
						errors++;
					end
				end
			end
			if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("%0t: timeout, no handshake for %0d cycles", $realtime, STALL_LIMIT);
				$display("vibrato_block_resampler_unit_tb NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Sender: a new frame only once the previous one has been taken.
	always @(negedge clk) begin
		logic     nv;
		in_item_t ni;
		if (arst_n) begin
			nv = src_valid;
			ni = src_item;
			if (!src_valid || src_took) begin
				nv = 1'b0;
				if (frame_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nv = 1'b1;
					ni = frame_q.pop_front();
				end
			end
			src_valid <= nv;
			src_item  <= ni;
		end
	end

	// Receiver: random stalls, plus one long hold-off to back the block up.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				dst_stall <= 1'b1;
			end else begin
				dst_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_frame(logic [15:0] a, logic [15:0] b);
		in_item_t it;
		it.sample_first  = a;
		it.sample_second = b;
		frame_q.push_back(it);
	endtask

	task automatic add_random(int n);
		repeat (n) add_frame(pick_sample(), pick_sample());
	endtask

	// Wait until every frame is in and every owed output is out, then let the
	// block finish any frame that owes nothing.
	task automatic drain();
		while (frame_q.size() != 0 || src_valid || owed_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, int unsigned val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		apply_reg(idx, CFG_DATA_W'(val));
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic int unsigned pick_len();
		if ($urandom_range(7) != 0) return $urandom_range(2, 12);
		case ($urandom_range(4))
			0: return 0;
			1: return 1;
			2: return 1024;
			3: return 2047;
			default: return $urandom_range(13, 64);
		endcase
	endfunction

	function automatic int unsigned pick_cycle();
		case ($urandom_range(5))
			0: return 4;
			1: return 8;
			2: return 0;
			3: return 8191;
			4: return 4096;
			default: return $urandom_range(0, 8191);
		endcase
	endfunction

	initial begin
		src_valid = 1'b0;
		src_item  = '0;
		dst_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_BLOCK_FRAMES;
		cfg_data  = '0;
		send_idle_pct = 11;
		recv_idle_pct = 71;
		hold_go   = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		src_took  = 1'b0;
		quiet_cycles = 0;
		errors = 0;
		frames_in = 0;
		frames_out = 0;
		blocks_done = 0;
		m_len   = BLOCK_FRAMES_RST;
		m_chans = CHANNEL_COUNT_RST;
		m_peak  = PEAK_FRAMES_RST;
		m_cycle = CYCLE_BLOCKS_RST;
		m_prior = '{0, 0};
		m_carry = '{0, 0};
		m_fpos = 0;
		m_cpos = 0;
		m_olen = 0;
		m_oidx = 0;
		m_acc  = 0;
		fill_sine();

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: long block, no modulation. Frame 0 owes nothing,
		// later frames one interpolated output each. Sample extremes here.
		add_frame(16'h7fff, 16'h8000);
		add_frame(16'h8000, 16'h7fff);
		add_frame(16'h0000, 16'hffff);
		add_frame(16'hffff, 16'h0000);
		add_frame(16'h7fff, 16'h7fff);
		add_frame(16'h8000, 16'h8000);
		drain();

		// Shortest block, one channel (second sample must be ignored), with
		// modulation over an 8-block cycle.
		write_reg(CFG_BLOCK_FRAMES, 2);
		write_reg(CFG_CHANNEL_COUNT, 1);
		write_reg(CFG_PEAK_FRAMES, 1);
		write_reg(CFG_CYCLE_BLOCKS, 8);
		add_frame(16'h7fff, 16'h1234);
		add_frame(16'h8000, 16'hffff);
		add_random(4);
		drain();

		// Back to stereo; run the cycle position up, then shrink the cycle
		// under it so it restarts at the next block.
		write_reg(CFG_CHANNEL_COUNT, 2);
		add_random(7);
		drain();
		write_reg(CFG_CYCLE_BLOCKS, 4);

		// Rewriting the block length mid-block starts a new block.
		write_reg(CFG_BLOCK_FRAMES, 3);
		write_reg(CFG_PEAK_FRAMES, 1023);
		add_random(1);
		drain();
		write_reg(CFG_BLOCK_FRAMES, 4);
		add_random(5);
		drain();

		// Random settings and frames, three idling regimes.
		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 3) begin
				send_idle_pct = 71;
				recv_idle_pct = 11;
			end else if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(CFG_BLOCK_FRAMES, pick_len());
			write_reg(CFG_CHANNEL_COUNT, $urandom_range(0, 3));
			write_reg(CFG_PEAK_FRAMES,
			          $urandom_range(1) ? $urandom_range(0, 6) : $urandom_range(0, 1023));
			write_reg(CFG_CYCLE_BLOCKS, pick_cycle());
			if (ph == 6) begin
				// receiver holds off while frames keep coming
				add_random(20);
				hold_go = 1'b1;
			end else begin
				add_random(7);
			end
			drain();
		end

		$display("Covered %0d input frames, %0d output frames, %0d finished blocks,",
		         frames_in, frames_out, blocks_done);
		$display("under one/two channels, block and cycle extremes and mixed stalls.");
		if (errors == 0 && owed_q.size() == 0) begin
			$display("vibrato_block_resampler_unit_tb OK");
		end else begin
			$display("vibrato_block_resampler_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
